// ===== sv/tscp_pkg.sv =====
// shared constants, types and helpers for the triangle slab clip block
package tscp_pkg;

  localparam int FRAC_BITS = 10;

  localparam int COORD_W = 32;
  localparam int Z_W     = 34;
  localparam int ZD_W    = Z_W + 1;
  localparam int ZM_W    = Z_W;
  localparam int DX_W    = COORD_W + 1;

  localparam int Q_FRAC = 16;
  localparam int Q_W    = Q_FRAC + 1;

  localparam int LANES = 4;
  localparam int LN_W  = 3;
  localparam int MAX_V = 5;
  localparam int CNT_W = 4;
  localparam int VI_W  = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int HZ_W       = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Z   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_Z = CFG_IDX_W'(1);

  localparam longint EPS       = ((longint'(1) << FRAC_BITS) + 50) / 100;
  localparam longint BAND_MIN  = longint'(10) << FRAC_BITS;
  localparam longint BAND_MAX  = longint'(50) << FRAC_BITS;
  localparam int     BAND_W    = $clog2(BAND_MAX + 1);
  localparam longint H_LO      = 10 * BAND_MIN;
  localparam longint H_HI      = 10 * BAND_MAX + 10;
  localparam int     H_W       = $clog2(H_HI);
  localparam int     DIV10_K   = H_W + 4;
  localparam int     DIV10_MW  = DIV10_K - 3;
  localparam longint DIV10_M   = ((longint'(1) << DIV10_K) + 9) / 10;
  localparam int     BP_W      = H_W + DIV10_MW;

  localparam int     S_W      = 67;
  localparam longint THR_RAW  = ((longint'(1) << (2 * FRAC_BITS)) * 2 + 500) / 1000;
  localparam longint THR      = (THR_RAW == 0) ? 1 : THR_RAW;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [Z_W-1:0]     z;
  } vtx_t;

  function automatic logic [ZM_W-1:0] zmag(logic signed [ZD_W-1:0] v);
    logic [ZD_W-1:0] u;
    u = v[ZD_W-1] ? ZD_W'(-v) : ZD_W'(v);
    return u[ZM_W-1:0];
  endfunction

  function automatic logic [DX_W-1:0] cmag(logic signed [DX_W-1:0] v);
    return v[DX_W-1] ? DX_W'(-v) : DX_W'(v);
  endfunction

endpackage

// ===== sv/tscp_if.sv =====
// valid/ready channel interfaces for triangles in and polygon vertices out
interface tscp_in_if;
  import tscp_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] a_x;
  logic signed [COORD_W-1:0] a_y;
  logic signed [COORD_W-1:0] a_z;
  logic signed [COORD_W-1:0] b_x;
  logic signed [COORD_W-1:0] b_y;
  logic signed [COORD_W-1:0] b_z;
  logic signed [COORD_W-1:0] c_x;
  logic signed [COORD_W-1:0] c_y;
  logic signed [COORD_W-1:0] c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

interface tscp_out_if;
  import tscp_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic [VI_W-1:0]           vertex_index;
  logic                      last_vertex;
  modport source (output valid, out_x, out_y, vertex_index, last_vertex, input ready);
  modport sink (input valid, out_x, out_y, vertex_index, last_vertex, output ready);
endinterface

// ===== sv/triangle_slab_clip_project.sv =====
// triangle slab clip with xy projection, top level
// Takes one triangle per beat on in_bus (valid/ready, vertices a, b, c as
// signed Q21.10) and clips it to the slab base_z - 0.01 <= z <= base_z + band,
// band being height_z / 10 held to 10..50 units. The clipped polygon is
// projected to xy and sent on out_bus one vertex per beat, counter-clockwise,
// with vertex_index counting from 0 and last_vertex on the final beat.
// Polygons under three vertices or with |area| below 0.001 send no beats.
// base_z (index 0) and height_z (index 1) are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while no triangle
// is in flight, as the block itself does not enforce this. The path runs
// through two clip pipelines of 12 stages each (eight of them a 2-bit-per-stage
// divider), three area stages and the output register.
// One triangle per cycle enters while in_bus.ready is high; a kept polygon
// holds the output register until its vertices (3 to 5) have all gone out,
// so the vertex count sets the sustained rate. Dropped triangles hold nothing.
// While a polygon's earlier vertices go out, or a vertex waits on a low
// out_bus.ready, the whole pipeline holds and in_bus.ready drops; nothing is
// lost or repeated. Reset clears both registers to 0 and empties the pipeline.
module triangle_slab_clip_project (
  input  logic                                clk,
  input  logic                                rst_n,
  tscp_in_if.sink                             in_bus,
  tscp_out_if.source                          out_bus,
  input  logic                                cfg_we,
  input  logic [tscp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tscp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tscp_pkg::*;

  localparam logic signed [S_W-1:0] AREA_T     = S_W'(THR);
  localparam logic signed [S_W-1:0] AREA_T_NEG = -S_W'(THR);
  localparam int PR_W = 2 * COORD_W;
  localparam int VX_W = $clog2(MAX_V);

  logic signed [COORD_W-1:0] base_z_r;
  logic [HZ_W-1:0]           height_z_r;
  logic [BAND_W-1:0]         band_r;
  logic [BAND_W-1:0]         band_nxt;
  logic [BP_W-1:0]           band_prod;
  logic signed [Z_W-1:0]     zlo;
  logic signed [Z_W-1:0]     zhi;

  logic en;
  vtx_t tri_v [LANES];

  logic             c1_valid;
  logic [CNT_W-1:0] c1_n;
  vtx_t             c1_v [MAX_V];
  vtx_t             c2_in_v [LANES];
  logic             c2_valid;
  logic [CNT_W-1:0] c2_n;
  vtx_t             c2_v [MAX_V];

  logic                   p1_valid_r;
  logic [CNT_W-1:0]       p1_n_r;
  vtx_t                   p1_v_r [MAX_V];
  logic signed [PR_W-1:0] p1_a_r [MAX_V];
  logic signed [PR_W-1:0] p1_b_r [MAX_V];
  logic signed [PR_W-1:0] p1_a [MAX_V];
  logic signed [PR_W-1:0] p1_b [MAX_V];

  logic                  p2_valid_r;
  logic [CNT_W-1:0]      p2_n_r;
  vtx_t                  p2_v_r [MAX_V];
  logic signed [S_W-1:0] p2_s01_r;
  logic signed [S_W-1:0] p2_s23_r;
  logic signed [S_W-1:0] p2_s4_r;

  logic                  p3_valid_r;
  logic [CNT_W-1:0]      p3_n_r;
  vtx_t                  p3_v_r [MAX_V];
  logic signed [S_W-1:0] p3_s_r;

  logic       keep;
  vtx_t       ord_v [MAX_V];
  logic       hold_valid_r;
  vtx_t       hold_v_r [MAX_V];
  logic [VI_W-1:0] hold_n_r;
  logic [VI_W-1:0] k_r;
  logic       last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_z_r   <= '0;
      height_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_Z:   base_z_r   <= signed'(cfg_wdata);
        CFG_HEIGHT_Z: height_z_r <= cfg_wdata[HZ_W-1:0];
        default: ;
      endcase
    end
  end

  // band = height_z / 10 by reciprocal, clamped
  always_comb begin
    band_prod = BP_W'(height_z_r[H_W-1:0]) * BP_W'(DIV10_M);
    if (height_z_r < HZ_W'(H_LO)) begin
      band_nxt = BAND_W'(BAND_MIN);
    end else if (height_z_r >= HZ_W'(H_HI)) begin
      band_nxt = BAND_W'(BAND_MAX);
    end else begin
      band_nxt = band_prod[DIV10_K +: BAND_W];
    end
  end

  always_ff @(posedge clk) begin
    band_r <= band_nxt;
  end

  assign zlo = Z_W'(base_z_r) - Z_W'(EPS);
  assign zhi = Z_W'(base_z_r) + signed'(Z_W'(band_r));

  assign last = (k_r == hold_n_r - VI_W'(1));
  assign en   = !hold_valid_r || (out_bus.ready && last);
  assign in_bus.ready = en;

  always_comb begin
    tri_v[0] = '{x: in_bus.a_x, y: in_bus.a_y, z: Z_W'(in_bus.a_z)};
    tri_v[1] = '{x: in_bus.b_x, y: in_bus.b_y, z: Z_W'(in_bus.b_z)};
    tri_v[2] = '{x: in_bus.c_x, y: in_bus.c_y, z: Z_W'(in_bus.c_z)};
    tri_v[3] = tri_v[0];
    for (int i = 0; i < LANES; i++) begin
      c2_in_v[i] = c1_v[i];
    end
  end

  tscp_clip u_clip_lo (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_bus.valid),
    .in_n       (LN_W'(3)),
    .in_v       (tri_v),
    .zp         (zlo),
    .keep_above (1'b1),
    .out_valid  (c1_valid),
    .out_n      (c1_n),
    .out_v      (c1_v)
  );

  tscp_clip u_clip_hi (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (c1_valid),
    .in_n       (c1_n[LN_W-1:0]),
    .in_v       (c2_in_v),
    .zp         (zhi),
    .keep_above (1'b0),
    .out_valid  (c2_valid),
    .out_n      (c2_n),
    .out_v      (c2_v)
  );

  // shoelace cross products
  always_comb begin
    logic [VX_W-1:0] j;
    for (int i = 0; i < MAX_V; i++) begin
      if (i == MAX_V - 1 || CNT_W'(i + 1) >= c2_n) begin
        j = '0;
      end else begin
        j = VX_W'(i + 1);
      end
      if (CNT_W'(i) < c2_n) begin
        p1_a[i] = c2_v[i].x * c2_v[j].y;
        p1_b[i] = c2_v[j].x * c2_v[i].y;
      end else begin
        p1_a[i] = '0;
        p1_b[i] = '0;
      end
    end
  end

  // keep test on vertex count and area, and reverse clockwise polygons
  always_comb begin
    logic [VI_W-1:0] src;
    keep = (p3_n_r >= CNT_W'(3)) && (p3_n_r <= CNT_W'(MAX_V)) &&
           ((p3_s_r >= AREA_T) || (p3_s_r <= AREA_T_NEG));
    for (int k = 0; k < MAX_V; k++) begin
      src = p3_s_r[S_W-1] ? p3_n_r[VI_W-1:0] - VI_W'(1) - VI_W'(k) : VI_W'(k);
      if (src > VI_W'(MAX_V - 1)) begin
        src = '0;
      end
      ord_v[k] = p3_v_r[src[VX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= c2_valid;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_n_r   <= c2_n;
      p1_v_r   <= c2_v;
      p1_a_r   <= p1_a;
      p1_b_r   <= p1_b;
      p2_n_r   <= p1_n_r;
      p2_v_r   <= p1_v_r;
      p2_s01_r <= S_W'(p1_a_r[0]) - S_W'(p1_b_r[0]) + S_W'(p1_a_r[1]) - S_W'(p1_b_r[1]);
      p2_s23_r <= S_W'(p1_a_r[2]) - S_W'(p1_b_r[2]) + S_W'(p1_a_r[3]) - S_W'(p1_b_r[3]);
      p2_s4_r  <= S_W'(p1_a_r[4]) - S_W'(p1_b_r[4]);
      p3_n_r   <= p2_n_r;
      p3_v_r   <= p2_v_r;
      p3_s_r   <= p2_s01_r + p2_s23_r + p2_s4_r;
      hold_v_r <= ord_v;
      hold_n_r <= p3_n_r[VI_W-1:0];
    end
  end

  // output register, one vertex per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      k_r          <= '0;
    end else if (en) begin
      hold_valid_r <= p3_valid_r && keep;
      k_r          <= '0;
    end else if (out_bus.ready) begin
      k_r <= k_r + VI_W'(1);
    end
  end

  assign out_bus.valid        = hold_valid_r;
  assign out_bus.out_x        = hold_v_r[k_r[VX_W-1:0]].x;
  assign out_bus.out_y        = hold_v_r[k_r[VX_W-1:0]].y;
  assign out_bus.vertex_index = k_r;
  assign out_bus.last_vertex  = last;

endmodule

// ===== sv/tscp_clip.sv =====
// pipelined clip of a polygon of up to four vertices against one z plane
module tscp_clip (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [tscp_pkg::LN_W-1:0]       in_n,
  input  tscp_pkg::vtx_t                  in_v [tscp_pkg::LANES],
  input  logic signed [tscp_pkg::Z_W-1:0] zp,
  input  logic                            keep_above,
  output logic                            out_valid,
  output logic [tscp_pkg::CNT_W-1:0]      out_n,
  output tscp_pkg::vtx_t                  out_v [tscp_pkg::MAX_V]
);
  import tscp_pkg::*;

  localparam int DIV_PER_ST = 2;
  localparam int DIV_STAGES = Q_FRAC / DIV_PER_ST;
  localparam int NST        = DIV_STAGES + 4;
  localparam int CAND       = 2 * LANES;
  localparam int LI_W       = $clog2(LANES);
  localparam int REM_W      = ZM_W + 1;
  localparam int PM_W       = DX_W + Q_W;
  localparam int ST_W       = PM_W - Q_FRAC;
  localparam int OI_W       = $clog2(MAX_V);

  typedef struct packed {
    logic                      emit_a;
    logic                      cut;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [Z_W-1:0]     az;
    logic                      sx;
    logic                      sy;
    logic [DX_W-1:0]           mx;
    logic [DX_W-1:0]           my;
    logic [REM_W-1:0]          rem;
    logic [ZM_W-1:0]           den;
    logic [Q_W-1:0]            q;
  } lane_t;

  typedef struct packed {
    logic                      emit_a;
    logic                      cut;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [Z_W-1:0]     az;
    logic                      sx;
    logic                      sy;
    logic [PM_W-1:0]           px;
    logic [PM_W-1:0]           py;
  } mul_t;

  // two restoring division steps, one quotient bit each
  function automatic lane_t div_stage(lane_t l);
    lane_t o;
    logic [REM_W-1:0] r2;
    o = l;
    for (int s = 0; s < DIV_PER_ST; s++) begin
      r2 = {o.rem[REM_W-2:0], 1'b0};
      if (r2 >= {1'b0, o.den}) begin
        r2  = r2 - {1'b0, o.den};
        o.q = {o.q[Q_W-2:0], 1'b1};
      end else begin
        o.q = {o.q[Q_W-2:0], 1'b0};
      end
      o.rem = r2;
    end
    return o;
  endfunction

  logic [NST-1:0] vld_r;
  lane_t          lane_a [LANES];
  lane_t          st_r [DIV_STAGES+1][LANES];
  mul_t           mul_r [LANES];
  vtx_t           cand [CAND];
  logic [CAND-1:0] cand_ok;
  vtx_t           cand_r [CAND];
  logic [CAND-1:0] cand_ok_r;
  vtx_t           pack_v [MAX_V];
  logic [CNT_W-1:0] pack_n;
  vtx_t           out_v_r [MAX_V];
  logic [CNT_W-1:0] out_n_r;

  // edge setup: inside tests, interpolation numerator and denominator
  always_comb begin
    logic [LI_W-1:0] nx;
    vtx_t va;
    vtx_t vb;
    logic ok;
    logic ina;
    logic inb;
    logic [ZM_W-1:0] num;
    logic [ZM_W-1:0] den;
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    for (int i = 0; i < LANES; i++) begin
      nx  = (LN_W'(i + 1) == in_n) ? '0 : LI_W'(i + 1);
      va  = in_v[i];
      vb  = in_v[nx];
      ok  = LN_W'(i) < in_n;
      ina = keep_above ? (va.z >= zp) : (va.z <= zp);
      inb = keep_above ? (vb.z >= zp) : (vb.z <= zp);
      num = zmag(ZD_W'(zp) - ZD_W'(va.z));
      den = zmag(ZD_W'(vb.z) - ZD_W'(va.z));
      dx  = DX_W'(vb.x) - DX_W'(va.x);
      dy  = DX_W'(vb.y) - DX_W'(va.y);
      lane_a[i].emit_a = ok && ina;
      lane_a[i].cut    = ok && (ina != inb);
      lane_a[i].ax     = va.x;
      lane_a[i].ay     = va.y;
      lane_a[i].az     = va.z;
      lane_a[i].sx     = dx[DX_W-1];
      lane_a[i].sy     = dy[DX_W-1];
      lane_a[i].mx     = cmag(dx);
      lane_a[i].my     = cmag(dy);
      lane_a[i].den    = den;
      // top quotient bit: the crossing lies at the far end
      if (num == den) begin
        lane_a[i].q   = Q_W'(1);
        lane_a[i].rem = '0;
      end else begin
        lane_a[i].q   = '0;
        lane_a[i].rem = REM_W'(num);
      end
    end
  end

  // intersection points and the ordered candidate list
  always_comb begin
    logic [ST_W-1:0] stx;
    logic [ST_W-1:0] sty;
    logic [ST_W-1:0] fx;
    logic [ST_W-1:0] fy;
    for (int i = 0; i < LANES; i++) begin
      stx = mul_r[i].px[PM_W-1:Q_FRAC];
      sty = mul_r[i].py[PM_W-1:Q_FRAC];
      fx  = mul_r[i].sx ? ST_W'(mul_r[i].ax) - stx : ST_W'(mul_r[i].ax) + stx;
      fy  = mul_r[i].sy ? ST_W'(mul_r[i].ay) - sty : ST_W'(mul_r[i].ay) + sty;
      cand[2*i].x       = mul_r[i].ax;
      cand[2*i].y       = mul_r[i].ay;
      cand[2*i].z       = mul_r[i].az;
      cand_ok[2*i]      = mul_r[i].emit_a;
      cand[2*i+1].x     = signed'(fx[COORD_W-1:0]);
      cand[2*i+1].y     = signed'(fy[COORD_W-1:0]);
      cand[2*i+1].z     = zp;
      cand_ok[2*i+1]    = mul_r[i].cut;
    end
  end

  // compaction of the kept candidates
  always_comb begin
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    for (int k = 0; k < MAX_V; k++) begin
      pack_v[k] = cand_r[0];
    end
    for (int j = 0; j < CAND; j++) begin
      if (cand_ok_r[j]) begin
        if (cnt < CNT_W'(MAX_V)) begin
          pack_v[cnt[OI_W-1:0]] = cand_r[j];
        end
        cnt = cnt + CNT_W'(1);
      end
    end
    pack_n = cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        st_r[0][i] <= lane_a[i];
        for (int s = 1; s <= DIV_STAGES; s++) begin
          st_r[s][i] <= div_stage(st_r[s-1][i]);
        end
        mul_r[i].emit_a <= st_r[DIV_STAGES][i].emit_a;
        mul_r[i].cut    <= st_r[DIV_STAGES][i].cut;
        mul_r[i].ax     <= st_r[DIV_STAGES][i].ax;
        mul_r[i].ay     <= st_r[DIV_STAGES][i].ay;
        mul_r[i].az     <= st_r[DIV_STAGES][i].az;
        mul_r[i].sx     <= st_r[DIV_STAGES][i].sx;
        mul_r[i].sy     <= st_r[DIV_STAGES][i].sy;
        mul_r[i].px     <= PM_W'(st_r[DIV_STAGES][i].mx) * PM_W'(st_r[DIV_STAGES][i].q);
        mul_r[i].py     <= PM_W'(st_r[DIV_STAGES][i].my) * PM_W'(st_r[DIV_STAGES][i].q);
      end
      cand_r    <= cand;
      cand_ok_r <= cand_ok;
      out_v_r   <= pack_v;
      out_n_r   <= pack_n;
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_n     = out_n_r;
  assign out_v     = out_v_r;

endmodule

// ===== sv/tscp_checker.sv =====
// port-level checks for the triangle slab clip block and their bind
module tscp_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [tscp_pkg::COORD_W-1:0]  out_x,
  input logic signed [tscp_pkg::COORD_W-1:0]  out_y,
  input logic [tscp_pkg::VI_W-1:0]            vertex_index,
  input logic                                 last_vertex
);
  import tscp_pkg::*;

  // a held vertex stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_y)))
    else $error("output beat dropped or changed while stalled");

  // vertices of one polygon come with consecutive indexes
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !last_vertex) |=>
    (out_valid && vertex_index == $past(vertex_index) + VI_W'(1)))
    else $error("vertex index did not advance within a polygon");

  // a polygon closes with three to five vertices
  a_last_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && last_vertex) |->
    (vertex_index >= VI_W'(2) && vertex_index <= VI_W'(MAX_V - 1)))
    else $error("polygon closed with a bad vertex count");

  // no triangle taken while a vertex is stalled
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  // a non-final vertex is never the one that frees the input
  a_mid_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !last_vertex) |-> !(in_valid && in_ready))
    else $error("input taken in the middle of a polygon");

endmodule

bind triangle_slab_clip_project tscp_checker u_tscp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .out_x        (out_bus.out_x),
  .out_y        (out_bus.out_y),
  .vertex_index (out_bus.vertex_index),
  .last_vertex  (out_bus.last_vertex)
);
